/* rtl/pts_pkg.sv */
`default_nettype none
package pts_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_W         = 32;
  localparam int TIMER_ID_W     = 4;
  localparam int FUNC_W         = 3;

  localparam logic [TIME_W-1:0] DEFAULT_INTERVAL = TIME_W'(1000);

  localparam logic [FUNC_W-1:0] FUNC_START        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_STOP         = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_INTERVAL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SET_LOCKED   = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [TIMER_ID_W-1:0] timer_id;
    logic [TIME_W-1:0]     interval_ms;
    logic                  lock_flag;
    logic [TIME_W-1:0]     now_ms;
  } pts_in_t;

  typedef struct packed {
    logic                  kind;
    logic [TIMER_ID_W-1:0] fired_id;
    logic                  ok;
    logic                  last;
  } pts_out_t;

  // Broadcast from the controller to every timer cell.
  typedef struct packed {
    logic                  cmd_vld;
    logic                  upd;
    logic                  shift;
    logic [FUNC_W-1:0]     func;
    logic [TIMER_ID_W-1:0] timer_id;
    logic [TIME_W-1:0]     interval_ms;
    logic                  lock_flag;
    logic [TIME_W-1:0]     now_ms;
  } pts_cmd_t;

  // One due timer travelling along the scan and sort chains.
  typedef struct packed {
    logic                  vld;
    logic [TIME_W-1:0]     key;
    logic [TIMER_ID_W-1:0] id;
  } pts_entry_t;

endpackage
`default_nettype wire

/* rtl/pts_stream_if.sv */
`default_nettype none
interface pts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/pts_timer_cell.sv */
`default_nettype none
module pts_timer_cell
  import pts_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pts_cmd_t   cmd_i,
  input  wire pts_entry_t scan_i,
  output pts_entry_t      scan_o,
  output logic            stop_hit_o
);

  localparam logic [TIMER_ID_W-1:0] MY_ID = TIMER_ID_W'(CELL_IDX);
  localparam bit ADDRESSABLE = CELL_IDX < (1 << TIMER_ID_W);

  logic              active_q, active_d;
  logic              locked_q, locked_d;
  logic [TIME_W-1:0] interval_q, interval_d;
  logic [TIME_W-1:0] expiry_q, expiry_d;
  pts_entry_t        scan_q, scan_d;

  logic              sel, due, fire, int_chg;
  logic [TIME_W-1:0] add_a, add_b, sum;

  always_comb begin
    sel     = cmd_i.cmd_vld && ADDRESSABLE && (cmd_i.timer_id == MY_ID);
    due     = active_q && (expiry_q <= cmd_i.now_ms);
    fire    = cmd_i.upd && due;
    int_chg = sel && (cmd_i.func == FUNC_SET_INTERVAL) &&
              (interval_q != cmd_i.interval_ms);
    // fixed-rate timers advance from their old expiry, others from now
    add_a   = (fire && locked_q) ? expiry_q : cmd_i.now_ms;
    add_b   = int_chg ? cmd_i.interval_ms : interval_q;
    sum     = add_a + add_b;

    active_d   = active_q;
    locked_d   = locked_q;
    interval_d = interval_q;
    expiry_d   = expiry_q;

    if (fire) begin
      expiry_d = sum;
    end
    if (sel) begin
      case (cmd_i.func)
        FUNC_START: begin
          active_d = 1'b1;
          expiry_d = sum;
        end
        FUNC_STOP: begin
          active_d = 1'b0;
        end
        FUNC_SET_INTERVAL: begin
          if (int_chg) begin
            interval_d = cmd_i.interval_ms;
            if (active_q) begin
              expiry_d = sum;
            end
          end
        end
        FUNC_SET_LOCKED: begin
          locked_d = cmd_i.lock_flag;
        end
        default: begin
        end
      endcase
    end

    scan_d = scan_q;
    if (cmd_i.upd) begin
      scan_d.vld = due;
      scan_d.key = expiry_q;
      scan_d.id  = MY_ID;
    end else if (cmd_i.shift) begin
      scan_d = scan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      locked_q   <= 1'b0;
      interval_q <= DEFAULT_INTERVAL;
      expiry_q   <= '0;
      scan_q     <= '0;
    end else begin
      active_q   <= active_d;
      locked_q   <= locked_d;
      interval_q <= interval_d;
      expiry_q   <= expiry_d;
      scan_q     <= scan_d;
    end
  end

  assign scan_o     = scan_q;
  assign stop_hit_o = sel && active_q;

endmodule
`default_nettype wire

/* rtl/pts_sort_cell.sv */
`default_nettype none
module pts_sort_cell
  import pts_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       pop_i,
  input  wire pts_entry_t in_i,
  input  wire pts_entry_t right_i,
  output pts_entry_t      pass_o,
  output pts_entry_t      stored_o
);

  pts_entry_t stored_q, stored_d;
  pts_entry_t pass_q, pass_d;
  logic       in_first;

  always_comb begin
    // order by expiry, equal expiries by the lower index
    in_first = (in_i.key < stored_q.key) ||
               ((in_i.key == stored_q.key) && (in_i.id < stored_q.id));

    stored_d = stored_q;
    pass_d   = '0;
    if (pop_i) begin
      stored_d = right_i;
    end else if (in_i.vld) begin
      if (!stored_q.vld) begin
        stored_d = in_i;
      end else if (in_first) begin
        // keep the earlier word, push the old one right
        stored_d = in_i;
        pass_d   = stored_q;
      end else begin
        pass_d = in_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      pass_q   <= '0;
    end else begin
      stored_q <= stored_d;
      pass_q   <= pass_d;
    end
  end

  assign pass_o   = pass_q;
  assign stored_o = stored_q;

endmodule
`default_nettype wire

/* rtl/periodic_timer_scheduler_core.sv */
// Periodic timer scheduler. Commands (start, stop, set interval, set locked)
// give one reply word in the cycle after they are taken. An update scans and
// sorts the due timers, then gives one word per fired timer and a done word.
// Every timer sits in its own cell; on an update all due timers are
// rescheduled at once, their old expiries are shifted out of the timer row one
// per cycle into a row of sorting cells that keeps them ordered by expiry
// (ties to the lower index), and the sorted row is then drained from its head.
// A new word is taken only after the previous one has delivered all its
// results.
`default_nettype none
module periodic_timer_scheduler_core
  import pts_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pts_stream_if.sink   in_i,
  pts_stream_if.source out_o
);

  localparam int CNT_W = (2 * NUM_TIMERS > 1) ? $clog2(2 * NUM_TIMERS) : 1;
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(2 * NUM_TIMERS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovld_q, ovld_d;
  pts_out_t         odata_q, odata_d;

  pts_in_t  in_word;
  pts_cmd_t cmd;
  logic     accept, out_free, pop, id_ok, func_ok, stop_hit;

  pts_entry_t             scan_link [NUM_TIMERS+1];
  pts_entry_t             sort_link [NUM_TIMERS+1];
  pts_entry_t             stored    [NUM_TIMERS+1];
  logic [NUM_TIMERS-1:0]  hits;

  assign in_word  = in_i.data;
  assign out_free = !ovld_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_i.ready;

  assign out_o.valid = ovld_q;
  assign out_o.data  = odata_q;

  always_comb begin
    cmd.cmd_vld     = accept && (in_word.func != FUNC_UPDATE) &&
                      (in_word.func <= FUNC_SET_LOCKED);
    cmd.upd         = accept && (in_word.func == FUNC_UPDATE);
    cmd.shift       = (state_q == ST_SCAN);
    cmd.func        = in_word.func;
    cmd.timer_id    = in_word.timer_id;
    cmd.interval_ms = in_word.interval_ms;
    cmd.lock_flag   = in_word.lock_flag;
    cmd.now_ms      = in_word.now_ms;
  end

  assign scan_link[NUM_TIMERS] = '0;
  assign stored[NUM_TIMERS]    = '0;

  always_comb begin
    sort_link[0]     = scan_link[0];
    sort_link[0].vld = scan_link[0].vld && (state_q == ST_SCAN);
  end

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cells
    pts_timer_cell #(
      .CELL_IDX(i)
    ) u_timer (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .scan_i    (scan_link[i+1]),
      .scan_o    (scan_link[i]),
      .stop_hit_o(hits[i])
    );

    pts_sort_cell u_sort (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .pop_i   (pop),
      .in_i    (sort_link[i]),
      .right_i (stored[i+1]),
      .pass_o  (sort_link[i+1]),
      .stored_o(stored[i])
    );
  end

  assign stop_hit = |hits;
  assign id_ok    = int'(in_word.timer_id) < NUM_TIMERS;
  assign func_ok  = in_word.func <= FUNC_SET_LOCKED;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q && !out_o.ready;
    odata_d = odata_q;
    pop     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.func == FUNC_UPDATE) begin
            state_d = ST_SCAN;
            cnt_d   = '0;
          end else begin
            ovld_d           = 1'b1;
            odata_d.kind     = 1'b0;
            odata_d.fired_id = in_word.timer_id;
            odata_d.ok       = func_ok && id_ok &&
                               ((in_word.func != FUNC_STOP) || stop_hit);
            odata_d.last     = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // feed one timer a cycle, then let the sort row settle
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SCAN_LAST) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          ovld_d = 1'b1;
          if (stored[0].vld) begin
            pop              = 1'b1;
            odata_d.kind     = 1'b1;
            odata_d.fired_id = stored[0].id;
            odata_d.ok       = 1'b1;
            odata_d.last     = 1'b0;
          end else begin
            odata_d.kind     = 1'b0;
            odata_d.fired_id = '0;
            odata_d.ok       = 1'b1;
            odata_d.last     = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
  end

endmodule
`default_nettype wire

/* verif/periodic_timer_scheduler_core_test.sv */
`timescale 1ns / 100ps
module periodic_timer_scheduler_core_test;
  import pts_pkg::*;

  localparam int NUM_T        = NUM_TIMERS_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_WORDS = 450;

  localparam logic [FUNC_W-1:0] FUNC_RSVD_FIRST = FUNC_SET_LOCKED + 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_LAST  = '1;
  localparam logic              KIND_REPLY      = 1'b0;
  localparam logic              KIND_FIRE       = 1'b1;

  logic clk;
  logic rst_n = 1'b0;

  pts_stream_if #(.T(pts_in_t))  in_if ();
  pts_stream_if #(.T(pts_out_t)) out_if ();

  periodic_timer_scheduler_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Timer table as the block should hold it.
  bit                tmr_active [NUM_T];
  bit                tmr_locked [NUM_T];
  logic [TIME_W-1:0] tmr_ivl    [NUM_T];
  logic [TIME_W-1:0] tmr_expiry [NUM_T];

  pts_in_t  cmd_words [$];
  pts_out_t sched_results [$];
  int       total_words;
  int       n_taken;
  int       n_errors;
  int       n_cycles;
  bit       word_taken;
  int       in_idle_pct;
  int       out_idle_pct;

  function automatic pts_out_t mk_result(logic kind, logic [TIMER_ID_W-1:0] id,
                                         logic ok, logic last);
    pts_out_t r;
    r.kind     = kind;
    r.fired_id = id;
    r.ok       = ok;
    r.last     = last;
    return r;
  endfunction

  // Apply one word to the timer table and queue the results it causes.
  function automatic void table_step(pts_in_t w);
    bit   due [NUM_T];
    int   best;
    logic ok;
    if (w.func == FUNC_UPDATE) begin
      for (int i = 0; i < NUM_T; i++) due[i] = tmr_active[i] && tmr_expiry[i] <= w.now_ms;
      do begin
        best = -1;
        for (int i = 0; i < NUM_T; i++)
          if (due[i] && (best < 0 || tmr_expiry[i] < tmr_expiry[best])) best = i;
        if (best >= 0) begin
          due[best] = 1'b0;
          if (tmr_locked[best]) tmr_expiry[best] = tmr_expiry[best] + tmr_ivl[best];
          else tmr_expiry[best] = w.now_ms + tmr_ivl[best];
          sched_results.insert(sched_results.size(),
                               mk_result(KIND_FIRE, TIMER_ID_W'(best), 1'b1, 1'b0));
        end
      end while (best >= 0);
      sched_results.insert(sched_results.size(), mk_result(KIND_REPLY, '0, 1'b1, 1'b1));
    end else begin
      ok = 1'b1;
      case (w.func)
        FUNC_START: begin
          tmr_active[w.timer_id] = 1'b1;
          tmr_expiry[w.timer_id] = w.now_ms + tmr_ivl[w.timer_id];
        end
        FUNC_STOP: begin
          ok = tmr_active[w.timer_id];
          tmr_active[w.timer_id] = 1'b0;
        end
        FUNC_SET_INTERVAL: begin
          if (tmr_ivl[w.timer_id] != w.interval_ms) begin
            tmr_ivl[w.timer_id] = w.interval_ms;
            if (tmr_active[w.timer_id])
              tmr_expiry[w.timer_id] = w.now_ms + w.interval_ms;
          end
        end
        FUNC_SET_LOCKED: tmr_locked[w.timer_id] = w.lock_flag;
        default: ok = 1'b0;
      endcase
      sched_results.insert(sched_results.size(),
                           mk_result(KIND_REPLY, w.timer_id, ok, 1'b1));
    end
  endfunction

  // Queue one input word. In random words, fields not used by a command carry random values so every bit toggles.
  task automatic push_word(logic [FUNC_W-1:0] func, logic [TIMER_ID_W-1:0] id,
                           logic [TIME_W-1:0] ivl, logic lock, logic [TIME_W-1:0] now);
    pts_in_t w;
    w.func        = func;
    w.timer_id    = id;
    w.interval_ms = ivl;
    w.lock_flag   = lock;
    w.now_ms      = now;
    cmd_words.insert(cmd_words.size(), w);
  endtask

  // Driver: note acceptance at the rising edge, drive at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      table_step(in_if.data);
      word_taken = 1'b1;
      n_taken++;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      case (n_taken * 3 / total_words)
        0: begin
          in_idle_pct  = 35;
          out_idle_pct = 59;
        end
        1: begin
          in_idle_pct  = 59;
          out_idle_pct = 35;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      if (!in_if.valid || word_taken) begin
        word_taken = 1'b0;
        if (cmd_words.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          in_if.data  <= cmd_words.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: compare each delivered word with the oldest expectation.
  always @(posedge clk) begin
    pts_out_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (sched_results.size() == 0) begin
        $error("unexpected result word: kind %0d id %0d ok %0d last %0d",
               out_if.data.kind, out_if.data.fired_id, out_if.data.ok, out_if.data.last);
        n_errors++;
      end else begin
        exp_w = sched_results.pop_front();
        if (out_if.data.kind !== exp_w.kind) begin
          $error("kind: expected %0d, got %0d", exp_w.kind, out_if.data.kind);
          n_errors++;
        end
        if (out_if.data.fired_id !== exp_w.fired_id) begin
          $error("fired_id: expected %0d, got %0d", exp_w.fired_id, out_if.data.fired_id);
          n_errors++;
        end
        if (out_if.data.ok !== exp_w.ok) begin
          $error("ok: expected %0d, got %0d", exp_w.ok, out_if.data.ok);
          n_errors++;
        end
        if (out_if.data.last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, out_if.data.last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0]     wall_ms;
    logic [TIME_W-1:0]     gen_ivl [NUM_T];
    logic [TIME_W-1:0]     ivl;
    logic [TIMER_ID_W-1:0] id;
    int                    pick;

    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    word_taken   = 1'b0;
    n_taken      = 0;
    n_errors     = 0;
    n_cycles     = 0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    for (int i = 0; i < NUM_T; i++) begin
      tmr_active[i] = 1'b0;
      tmr_locked[i] = 1'b0;
      tmr_ivl[i]    = DEFAULT_INTERVAL;
      tmr_expiry[i] = '0;
      gen_ivl[i]    = DEFAULT_INTERVAL;
    end

    // Directed: empty update, stop of an idle timer, restart, equal interval,
    // re-arm on interval change, wrap of the expiry, fire order and ties,
    // reserved func codes, update at the top of the time range.
    push_word(FUNC_UPDATE, 4'd0, '0, 1'b0, '0);
    push_word(FUNC_STOP, 4'd0, '0, 1'b0, '0);
    push_word(FUNC_START, 4'd0, '1, 1'b1, '0);
    push_word(FUNC_START, 4'd15, '0, 1'b0, '0);
    push_word(FUNC_START, 4'd0, '0, 1'b0, 32'd0);
    push_word(FUNC_SET_INTERVAL, 4'd15, DEFAULT_INTERVAL, 1'b0, 32'd50);
    push_word(FUNC_SET_INTERVAL, 4'd15, 32'd500, 1'b0, 32'd100);
    push_word(FUNC_SET_LOCKED, 4'd0, '0, 1'b1, '0);
    push_word(FUNC_SET_LOCKED, 4'd3, '1, 1'b0, '1);
    push_word(FUNC_SET_INTERVAL, 4'd3, '1, 1'b0, '0);
    push_word(FUNC_START, 4'd3, '0, 1'b0, 32'd1);
    push_word(FUNC_UPDATE, 4'd9, '0, 1'b0, 32'd1000);
    push_word(FUNC_SET_INTERVAL, 4'd5, '0, 1'b0, 32'd1500);
    push_word(FUNC_START, 4'd5, '0, 1'b0, 32'd2000);
    push_word(FUNC_START, 4'd8, '0, 1'b0, 32'd2000);
    push_word(FUNC_START, 4'd7, '0, 1'b0, 32'd2000);
    push_word(FUNC_UPDATE, 4'd0, '0, 1'b0, 32'd3000);
    push_word(FUNC_RSVD_LAST, 4'd15, '1, 1'b1, '1);
    push_word(FUNC_RSVD_FIRST, 4'd0, '0, 1'b0, '0);
    push_word(FUNC_UPDATE, 4'd15, '1, 1'b1, '1);
    push_word(FUNC_STOP, 4'd15, '0, 1'b0, '0);
    push_word(FUNC_STOP, 4'd15, '0, 1'b0, '0);
    push_word(FUNC_UPDATE, 4'd0, '0, 1'b0, '1);
    gen_ivl[15] = 32'd500;
    gen_ivl[3]  = '1;
    gen_ivl[5]  = '0;

    // Random: mostly a coherent timeline of commands and rising update times.
    wall_ms = 32'd10000;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99);
      id   = TIMER_ID_W'($urandom_range(NUM_T - 1));
      if (pick < 35) begin
        if ($urandom_range(19) == 0) wall_ms = $urandom;
        else wall_ms = wall_ms + $urandom_range(300);
        push_word(FUNC_UPDATE, TIMER_ID_W'($urandom), $urandom, 1'($urandom), wall_ms);
      end else if (pick < 55) begin
        push_word(FUNC_START, id, $urandom, 1'($urandom), wall_ms);
      end else if (pick < 65) begin
        push_word(FUNC_STOP, id, $urandom, 1'($urandom), wall_ms);
      end else if (pick < 80) begin
        case ($urandom_range(9))
          0:       ivl = $urandom;
          1:       ivl = gen_ivl[id];
          2:       ivl = '0;
          default: ivl = $urandom_range(400);
        endcase
        gen_ivl[id] = ivl;
        push_word(FUNC_SET_INTERVAL, id, ivl, 1'($urandom), wall_ms);
      end else if (pick < 92) begin
        push_word(FUNC_SET_LOCKED, id, $urandom, 1'($urandom), wall_ms);
      end else begin
        push_word(FUNC_W'($urandom_range(FUNC_RSVD_FIRST, FUNC_RSVD_LAST)), id, $urandom,
                  1'($urandom), $urandom);
      end
    end
    total_words = cmd_words.size();

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    while (cmd_words.size() != 0 || in_if.valid) @(posedge clk);
    while (sched_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
